### rtl/command_frame_receiver_unit_macros.svh
// Assertion macros for the command frame receiver checker.
// Expects clk and rst_n in scope where used.
`ifndef COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_UNIT_MACROS_SVH

// checked only while out of reset
`define CFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CFR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/cfr_pkg.sv
// Shared types, constants and helper functions for the command frame receiver.
// No dependencies.
`default_nettype none

package cfr_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int FRAME_BYTES = 9;

    localparam logic [7:0] DEVICE_ID_RESET = 8'd1;

    localparam logic [7:0] CMD_FITNESS  = 8'h64;
    localparam logic [7:0] CMD_LIMITS   = 8'h50;
    localparam logic [7:0] CMD_CRASH    = 8'h51;
    localparam logic [7:0] CMD_IGNORE_A = 8'h70;
    localparam logic [7:0] CMD_IGNORE_B = 8'h05;

    localparam logic [3:0] POS_ID  = 4'd0;
    localparam logic [3:0] POS_CMD = 4'd1;
    localparam logic [3:0] POS_CRC = 4'd9;

    localparam logic [3:0] SET_MODE         = 4'd0;
    localparam logic [3:0] SET_TORQUE_L     = 4'd1;
    localparam logic [3:0] SET_TORQUE_R     = 4'd2;
    localparam logic [3:0] SET_CLEAR_L      = 4'd3;
    localparam logic [3:0] SET_CLEAR_R      = 4'd4;
    localparam logic [3:0] SET_LIM_SPEED    = 4'd5;
    localparam logic [3:0] SET_LIM_DIST     = 4'd6;
    localparam logic [3:0] SET_LIM_FORCE_L  = 4'd7;
    localparam logic [3:0] SET_LIM_FORCE_R  = 4'd8;
    localparam logic [3:0] SET_LIM_LEVEL    = 4'd9;
    localparam logic [3:0] SET_LIM_LOW      = 4'd10;
    localparam logic [3:0] SET_LIM_HIGH     = 4'd11;
    localparam logic [3:0] SET_CRASH_SPEED  = 4'd12;

    localparam logic [7:0] CLEAR_CODE_L = 8'd1;
    localparam logic [7:0] CLEAR_CODE_R = 8'd2;

    localparam logic [7:0] FIT_TORQUE_MAX  = 8'd80;
    localparam logic [7:0] LIM_SPEED_MAX   = 8'd30;
    localparam logic [7:0] LIM_DIST_MAX    = 8'd200;
    localparam logic [7:0] LIM_FORCE_MAX   = 8'd50;
    localparam logic [7:0] LIM_LEVEL_MAX   = 8'd6;
    localparam logic [7:0] LIM_LOW_MIN     = 8'd4;
    localparam logic [7:0] LIM_LOW_MAX     = 8'd14;
    localparam logic [7:0] LIM_HIGH_MIN    = 8'd3;
    localparam logic [7:0] LIM_HIGH_MAX    = 8'd40;
    localparam logic [7:0] CRASH_SPEED_MAX = 8'd200;

    localparam logic [15:0] SCALE_UNIT  = 16'd1;
    localparam logic [15:0] SCALE_198   = 16'd198;
    localparam logic [15:0] SCALE_20    = 16'd20;
    // x*2048/28 = x*512/7, done as (x*37450)>>9, exact for x <= 50
    localparam logic [15:0] SCALE_RECIP = 16'd37450;
    localparam int          RECIP_SHIFT = 9;

    typedef enum logic [1:0] {
        OP_FITNESS,
        OP_LIMITS,
        OP_CRASH
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SET,
        BK_ECHO
    } back_state_t;

    typedef struct packed {
        op_t                          op;
        logic [7:0]                   arg;
        logic [FRAME_BYTES-1:0][7:0]  bytes;
    } job_t;

    // CRC-8/MAXIM, reflected poly 0x31
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 8'h8C) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] clamp8(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
        logic [7:0] r;
        r = v;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    function automatic logic cmd_known(input logic [7:0] b);
        return (b == CMD_FITNESS) || (b == CMD_LIMITS) || (b == CMD_CRASH) ||
               (b == CMD_IGNORE_A) || (b == CMD_IGNORE_B);
    endfunction

endpackage

`default_nettype wire

### rtl/command_frame_receiver_unit.sv
// Top level of the command frame receiver: front end, job queue, back end.
// Depends on cfr_pkg, cfr_front, cfr_queue, cfr_back.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   in       | in_valid / in_stall   | rx_byte, start_mode_active
//   out      | out_valid / out_stall | out_kind, setting_index, setting_value,
//            |                       | reply_byte, last
//   cfg      | cfg_valid / cfg_ready | cfg_data (device id)
//
// One byte is taken per cycle while in_stall is low; a frame's final byte queues its job the
// same cycle, if the frame yields one. The back-end sequencer loads a job, then gives one
// result per unstalled cycle: up to 17 results per frame.
// in_stall rises only while the job queue is full (QueueDepth frames pending).
// Reset clears control state and sets the device id to 1; no clearing pass.
`default_nettype none

module command_frame_receiver_unit
    import cfr_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        start_mode_active,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             out_kind,
    output logic [3:0]       setting_index,
    output logic [13:0]      setting_value,
    output logic [7:0]       reply_byte,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    logic accept;
    logic push, pop, full, empty;
    job_t push_job, head_job;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !in_stall;

    cfr_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .accept            (accept),
        .rx_byte           (rx_byte),
        .start_mode_active (start_mode_active),
        .push              (push),
        .job               (push_job)
    );

    cfr_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (head_job),
        .empty    (empty)
    );

    cfr_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (empty),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_kind      (out_kind),
        .setting_index (setting_index),
        .setting_value (setting_value),
        .reply_byte    (reply_byte),
        .last          (last)
    );

endmodule

`default_nettype wire

### rtl/cfr_front.sv
// Front end: byte hunt, frame capture, running CRC and job classification.
// Depends on cfr_pkg.
`default_nettype none

module cfr_front
    import cfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [7:0] cfg_data,
    input  wire logic       accept,
    input  wire logic [7:0] rx_byte,
    input  wire logic       start_mode_active,
    output logic            push,
    output job_t            job
);

    logic [7:0] device_id_reg;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] crc_reg, crc_next;
    logic [7:0] bytes_reg [FRAME_BYTES];
    logic       store;
    logic       job_ok;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            device_id_reg <= DEVICE_ID_RESET;
            pos_reg       <= POS_ID;
            crc_reg       <= 8'd0;
        end else begin
            if (cfg_write) begin
                device_id_reg <= cfg_data;
            end
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk) begin
        if (store) begin
            bytes_reg[pos_reg] <= rx_byte;
        end
    end

    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        store    = 1'b0;
        push     = 1'b0;
        if (accept) begin
            priority if (pos_reg == POS_ID) begin
                if (rx_byte == device_id_reg) begin
                    store    = 1'b1;
                    crc_next = crc_update(8'd0, rx_byte);
                    pos_next = POS_CMD;
                end
            end else if (bytes_reg[0] != device_id_reg) begin
                pos_next = POS_ID;
            end else if (pos_reg == POS_CMD && !cmd_known(rx_byte)) begin
                pos_next = POS_ID;
            end else if (pos_reg < POS_CRC) begin
                store    = 1'b1;
                crc_next = crc_update(crc_reg, rx_byte);
                pos_next = pos_reg + 4'd1;
            end else begin
                pos_next = POS_ID;
                push     = (rx_byte == crc_reg) && job_ok;
            end
        end
    end

    always_comb begin
        job.bytes[0] = bytes_reg[0];
        job.bytes[1] = bytes_reg[1];
        job.arg      = clamp8(bytes_reg[2], 8'd0, CRASH_SPEED_MAX);
        for (int i = 2; i < FRAME_BYTES; i++) begin
            job.bytes[i] = bytes_reg[i];
        end
        priority if (bytes_reg[1] == CMD_FITNESS) begin
            job.op       = OP_FITNESS;
            job_ok       = !start_mode_active;
            job.bytes[3] = clamp8(bytes_reg[3], 8'd0, FIT_TORQUE_MAX);
            job.bytes[6] = clamp8(bytes_reg[6], 8'd0, FIT_TORQUE_MAX);
        end else if (bytes_reg[1] == CMD_LIMITS) begin
            job.op       = OP_LIMITS;
            job_ok       = 1'b1;
            job.bytes[2] = clamp8(bytes_reg[2], 8'd0, LIM_SPEED_MAX);
            job.bytes[3] = clamp8(bytes_reg[3], 8'd0, LIM_DIST_MAX);
            job.bytes[4] = clamp8(bytes_reg[4], 8'd0, LIM_FORCE_MAX);
            job.bytes[5] = clamp8(bytes_reg[5], 8'd0, LIM_FORCE_MAX);
            job.bytes[6] = clamp8(bytes_reg[6], 8'd0, LIM_LEVEL_MAX);
            job.bytes[7] = clamp8(bytes_reg[7], LIM_LOW_MIN, LIM_LOW_MAX);
            job.bytes[8] = clamp8(bytes_reg[8], LIM_HIGH_MIN, LIM_HIGH_MAX);
        end else if (bytes_reg[1] == CMD_CRASH) begin
            job.op = OP_CRASH;
            job_ok = 1'b1;
            for (int i = 2; i < FRAME_BYTES; i++) begin
                job.bytes[i] = 8'd0;
            end
        end else begin
            // ignored commands: consumed, no job
            job.op = OP_FITNESS;
            job_ok = 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/cfr_queue.sv
// Small job FIFO between front and back end.
// Depends on cfr_pkg.
`default_nettype none

module cfr_queue
    import cfr_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  job_t      push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    job_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + CntW'(1);
                2'b01:   count_reg <= count_reg - CntW'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/cfr_back.sv
// Back end: walks a job through its setting writes and the echo reply.
// Depends on cfr_pkg.
`default_nettype none

module cfr_back
    import cfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        empty,
    input  job_t             head_job,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             out_kind,
    output logic [3:0]       setting_index,
    output logic [13:0]      setting_value,
    output logic [7:0]       reply_byte,
    output logic             last
);

    back_state_t state_reg, state_next;
    job_t        job_reg, job_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  epos_reg, epos_next;
    logic [7:0]  crc_reg, crc_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, kind_next;
    logic [3:0]  sidx_reg, sidx_next;
    logic [13:0] sval_reg, sval_next;
    logic [7:0]  rb_reg, rb_next;
    logic        last_reg, last_next;

    logic        advance, load_out;
    logic [7:0]  mult_a;
    logic [15:0] mult_k;
    logic        use_recip;
    logic [23:0] product;
    logic [13:0] scaled;

    assign advance = !out_valid_reg || !out_stall;

    always_comb begin
        mult_a    = 8'd0;
        mult_k    = SCALE_UNIT;
        use_recip = 1'b0;
        case (idx_reg)
            SET_MODE:        begin mult_a = job_reg.bytes[2]; mult_k = SCALE_UNIT; end
            SET_TORQUE_L:    begin mult_a = job_reg.bytes[3]; mult_k = SCALE_198; end
            SET_TORQUE_R:    begin mult_a = job_reg.bytes[6]; mult_k = SCALE_198; end
            SET_LIM_SPEED:   begin mult_a = job_reg.bytes[2]; mult_k = SCALE_20; end
            SET_LIM_DIST:    begin mult_a = job_reg.bytes[3]; mult_k = SCALE_20; end
            SET_LIM_FORCE_L: begin
                mult_a    = job_reg.bytes[4];
                mult_k    = SCALE_RECIP;
                use_recip = 1'b1;
            end
            SET_LIM_FORCE_R: begin
                mult_a    = job_reg.bytes[5];
                mult_k    = SCALE_RECIP;
                use_recip = 1'b1;
            end
            SET_LIM_LEVEL:   begin mult_a = job_reg.bytes[6]; mult_k = SCALE_198; end
            SET_LIM_LOW:     begin mult_a = job_reg.bytes[7]; mult_k = SCALE_198; end
            SET_LIM_HIGH:    begin mult_a = job_reg.bytes[8]; mult_k = SCALE_198; end
            SET_CRASH_SPEED: begin mult_a = job_reg.arg;      mult_k = SCALE_20; end
            default:         begin mult_a = 8'd0;             mult_k = SCALE_UNIT; end
        endcase
        product = 24'(mult_a) * 24'(mult_k);
        scaled  = use_recip ? 14'(product >> RECIP_SHIFT) : 14'(product);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        job_reg  <= job_next;
        idx_reg  <= idx_next;
        epos_reg <= epos_next;
        crc_reg  <= crc_next;
        kind_reg <= kind_next;
        sidx_reg <= sidx_next;
        sval_reg <= sval_next;
        rb_reg   <= rb_next;
        last_reg <= last_next;
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        epos_next  = epos_reg;
        crc_next   = crc_reg;
        kind_next  = kind_reg;
        sidx_next  = sidx_reg;
        sval_next  = sval_reg;
        rb_next    = rb_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        load_out   = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (!empty) begin
                    pop        = 1'b1;
                    job_next   = head_job;
                    state_next = BK_SET;
                    unique case (head_job.op)
                        OP_LIMITS: idx_next = SET_LIM_SPEED;
                        OP_CRASH:  idx_next = SET_CRASH_SPEED;
                        default:   idx_next = SET_MODE;
                    endcase
                end
            end
            BK_SET: begin
                if (advance) begin
                    load_out  = 1'b1;
                    kind_next = 1'b1;
                    sidx_next = idx_reg;
                    sval_next = scaled;
                    rb_next   = 8'd0;
                    last_next = 1'b0;
                    epos_next = 4'd0;
                    crc_next  = 8'd0;
                    unique case (job_reg.op)
                        OP_FITNESS: begin
                            priority if (idx_reg == SET_TORQUE_R) begin
                                priority if (job_reg.bytes[7] == CLEAR_CODE_L) begin
                                    idx_next = SET_CLEAR_L;
                                end else if (job_reg.bytes[7] == CLEAR_CODE_R) begin
                                    idx_next = SET_CLEAR_R;
                                end else begin
                                    state_next = BK_ECHO;
                                end
                            end else if (idx_reg == SET_CLEAR_L || idx_reg == SET_CLEAR_R) begin
                                state_next = BK_ECHO;
                            end else begin
                                idx_next = idx_reg + 4'd1;
                            end
                        end
                        OP_LIMITS: begin
                            if (idx_reg == SET_LIM_HIGH) begin
                                state_next = BK_ECHO;
                            end else begin
                                idx_next = idx_reg + 4'd1;
                            end
                        end
                        default: state_next = BK_ECHO;
                    endcase
                end
            end
            BK_ECHO: begin
                if (advance) begin
                    load_out  = 1'b1;
                    kind_next = 1'b0;
                    sidx_next = 4'd0;
                    sval_next = 14'd0;
                    if (epos_reg == POS_CRC) begin
                        rb_next    = crc_reg;
                        last_next  = 1'b1;
                        state_next = BK_IDLE;
                    end else begin
                        rb_next   = job_reg.bytes[epos_reg];
                        last_next = 1'b0;
                        crc_next  = crc_update(crc_reg, job_reg.bytes[epos_reg]);
                        epos_next = epos_reg + 4'd1;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (!out_stall) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_kind      = kind_reg;
    assign setting_index = sidx_reg;
    assign setting_value = sval_reg;
    assign reply_byte    = rb_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

### rtl/cfr_checker.sv
// Port-level checker for the command frame receiver, bound to the top level.
// Depends on cfr_pkg and command_frame_receiver_unit_macros.svh.
`default_nettype none

`include "command_frame_receiver_unit_macros.svh"

module cfr_checker
    import cfr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        out_kind,
    input wire logic [3:0]  setting_index,
    input wire logic [13:0] setting_value,
    input wire logic [7:0]  reply_byte,
    input wire logic        last
);

    `CFR_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |=> !out_valid, "out_valid high in reset")
    `CFR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(reply_byte), "stalled result dropped or changed")
    `CFR_ASSERT(a_set_fields, out_valid && out_kind |-> reply_byte == 8'd0 && !last && setting_index <= SET_CRASH_SPEED, "bad setting write fields")
    `CFR_ASSERT(a_reply_fields, out_valid && !out_kind |-> setting_index == 4'd0 && setting_value == 14'd0, "bad reply byte fields")

endmodule

bind command_frame_receiver_unit cfr_checker u_cfr_checker (.*);

`default_nettype wire

### bench/cfr_bench_pkg.sv
// Bench-side helpers for the command frame receiver: the CRC-8/MAXIM step and the
// encoding of the result kind. No dependencies; used by the checker and tb_top.
package cfr_bench_pkg;

    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_SETTING = 1'b1;

    // bit-serial, LSB first, reflected poly 0x31
    function automatic logic [7:0] crc8_maxim_step(input logic [7:0] acc,
                                                   input logic [7:0] din);
        logic [7:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ din[k])
            begin
                r = {1'b0, r[7:1]} ^ 8'h8C;
            end
            else
            begin
                r = {1'b0, r[7:1]};
            end
        end
        return r;
    endfunction

endpackage

### bench/cfr_frame_checker.sv
// Checker for command_frame_receiver_unit: tracks the device id and the frame hunt,
// predicts setting writes and echo words, compares every accepted output word.
// Depends on cfr_pkg and cfr_bench_pkg.
module cfr_frame_checker
    import cfr_pkg::*;
    import cfr_bench_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        start_mode_active,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        out_kind,
    input  logic [3:0]  setting_index,
    input  logic [13:0] setting_value,
    input  logic [7:0]  reply_byte,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    output int          faults,
    output int          words_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        kind;
        logic [3:0]  idx;
        logic [13:0] value;
        logic [7:0]  echo;
        logic        fin;
    } frame_word_t;

    frame_word_t due_words[$];
    logic [7:0]  id_reg;
    logic [7:0]  held [0:8];
    logic [3:0]  slot;
    logic [7:0]  crc_acc;
    int          fault_tally = 0;

    assign faults = fault_tally;

    task automatic log_fault(input string msg);
        if (fault_tally < 100)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
        fault_tally = fault_tally + 1;
    endtask

    function automatic logic [7:0] clip_u8(input logic [7:0] x, input logic [7:0] lo,
                                           input logic [7:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    task automatic push_setting(input logic [3:0] idx, input int v);
        due_words.push_back('{KIND_SETTING, idx, 14'(v), 8'h00, 1'b0});
    endtask

    task automatic push_echo(input logic [7:0] d [0:8]);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < 9; i++)
        begin
            c = crc8_maxim_step(c, d[i]);
            due_words.push_back('{KIND_REPLY, 4'd0, 14'd0, d[i], 1'b0});
        end
        due_words.push_back('{KIND_REPLY, 4'd0, 14'd0, c, 1'b1});
    endtask

    task automatic decode_frame(input logic sm);
        logic [7:0] d [0:8];
        d = held;
        case (d[1])
            CMD_FITNESS:
            begin
                if (!sm)
                begin
                    d[3] = clip_u8(d[3], 8'd0, FIT_TORQUE_MAX);
                    d[6] = clip_u8(d[6], 8'd0, FIT_TORQUE_MAX);
                    push_setting(SET_MODE, int'(d[2]));
                    push_setting(SET_TORQUE_L, int'(d[3]) * 198);
                    push_setting(SET_TORQUE_R, int'(d[6]) * 198);
                    if (d[7] == CLEAR_CODE_L)
                    begin
                        push_setting(SET_CLEAR_L, 0);
                    end
                    if (d[7] == CLEAR_CODE_R)
                    begin
                        push_setting(SET_CLEAR_R, 0);
                    end
                    push_echo(d);
                end
            end
            CMD_LIMITS:
            begin
                d[2] = clip_u8(d[2], 8'd0, LIM_SPEED_MAX);
                d[3] = clip_u8(d[3], 8'd0, LIM_DIST_MAX);
                d[4] = clip_u8(d[4], 8'd0, LIM_FORCE_MAX);
                d[5] = clip_u8(d[5], 8'd0, LIM_FORCE_MAX);
                d[6] = clip_u8(d[6], 8'd0, LIM_LEVEL_MAX);
                d[7] = clip_u8(d[7], LIM_LOW_MIN, LIM_LOW_MAX);
                d[8] = clip_u8(d[8], LIM_HIGH_MIN, LIM_HIGH_MAX);
                push_setting(SET_LIM_SPEED, int'(d[2]) * 20);
                push_setting(SET_LIM_DIST, int'(d[3]) * 20);
                push_setting(SET_LIM_FORCE_L, int'(d[4]) * 2048 / 28);
                push_setting(SET_LIM_FORCE_R, int'(d[5]) * 2048 / 28);
                push_setting(SET_LIM_LEVEL, int'(d[6]) * 198);
                push_setting(SET_LIM_LOW, int'(d[7]) * 198);
                push_setting(SET_LIM_HIGH, int'(d[8]) * 198);
                push_echo(d);
            end
            CMD_CRASH:
            begin
                push_setting(SET_CRASH_SPEED, int'(clip_u8(d[2], 8'd0, CRASH_SPEED_MAX)) * 20);
                for (int i = 2; i < 9; i++)
                begin
                    d[i] = 8'h00;
                end
                push_echo(d);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic take_rx_byte(input logic [7:0] b, input logic sm);
        if (slot == POS_ID)
        begin
            if (b == id_reg)
            begin
                held[0] = b;
                crc_acc = crc8_maxim_step(8'h00, b);
                slot = POS_CMD;
            end
        end
        else if (held[0] != id_reg)
        begin
            slot = POS_ID;
        end
        else if (slot == POS_CMD && b != CMD_FITNESS && b != CMD_LIMITS && b != CMD_CRASH
                 && b != CMD_IGNORE_A && b != CMD_IGNORE_B)
        begin
            slot = POS_ID;
        end
        else if (slot < POS_CRC)
        begin
            held[slot] = b;
            crc_acc = crc8_maxim_step(crc_acc, b);
            slot = slot + 4'd1;
        end
        else
        begin
            slot = POS_ID;
            if (b == crc_acc)
            begin
                decode_frame(sm);
            end
        end
    endtask

    task automatic check_word();
        frame_word_t w;
        if (due_words.size() == 0)
        begin
            log_fault($sformatf("unexpected word kind=%0d idx=%0d value=%0d echo=%02h last=%0d",
                                out_kind, setting_index, setting_value, reply_byte, last));
        end
        else
        begin
            w = due_words.pop_front();
            if (out_kind !== w.kind)
                log_fault($sformatf("out_kind %0d, want %0d", out_kind, w.kind));
            if (setting_index !== w.idx)
                log_fault($sformatf("setting_index %0d, want %0d", setting_index, w.idx));
            if (setting_value !== w.value)
                log_fault($sformatf("setting_value %0d, want %0d", setting_value, w.value));
            if (reply_byte !== w.echo)
                log_fault($sformatf("reply_byte %02h, want %02h", reply_byte, w.echo));
            if (last !== w.fin)
                log_fault($sformatf("last %0d, want %0d", last, w.fin));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg = DEVICE_ID_RESET;
            slot = POS_ID;
            crc_acc = 8'h00;
            due_words.delete();
            words_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                id_reg = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                check_word();
            end
            if (in_valid && !in_stall)
            begin
                take_rx_byte(rx_byte, start_mode_active);
            end
            words_due <= due_words.size();
        end
    end

endmodule

### bench/tb_top.sv
// Testbench top for command_frame_receiver_unit: clock, reset, byte and id stimulus,
// random output stalls, verdict. Depends on cfr_pkg, cfr_bench_pkg, cfr_frame_checker.
module tb_top;
    import cfr_pkg::*;
    import cfr_bench_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 64;
    localparam int PHASE_ITEMS = 65;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        start_mode_active = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        out_kind;
    logic [3:0]  setting_index;
    logic [13:0] setting_value;
    logic [7:0]  reply_byte;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;

    int          faults;
    int          words_due;
    int          cycles = 0;
    int          items = 0;
    int          hold_left = 0;
    bit          calm = 1'b0;
    logic [7:0]  cur_id;
    logic [7:0]  fbuf [0:9];

    command_frame_receiver_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .start_mode_active (start_mode_active),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_kind          (out_kind),
        .setting_index     (setting_index),
        .setting_value     (setting_value),
        .reply_byte        (reply_byte),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data)
    );

    cfr_frame_checker u_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .rx_byte           (rx_byte),
        .start_mode_active (start_mode_active),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .out_kind          (out_kind),
        .setting_index     (setting_index),
        .setting_value     (setting_value),
        .reply_byte        (reply_byte),
        .last              (last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .faults            (faults),
        .words_due         (words_due)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // output side: random stall after each accepted word, random stall while idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                hold_left = calm ? 0 : $urandom_range(0, 4);
                out_stall <= (hold_left != 0);
            end
            else if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= (hold_left != 0);
            end
            else
            begin
                out_stall <= !out_valid && !calm && ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            rx_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        start_mode_active <= sm;
        do @(posedge clk); while (in_stall);
        items = items + 1;
    endtask

    // sends fbuf[0..8] plus CRC, optionally corrupted; sm_last applies to the CRC word
    task automatic send_frame(input logic bad_crc, input logic sm_last);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < 9; i++)
        begin
            c = crc8_maxim_step(c, fbuf[i]);
        end
        fbuf[9] = bad_crc ? (c ^ 8'($urandom_range(1, 255))) : c;
        for (int i = 0; i < 9; i++)
        begin
            send_byte(fbuf[i], 1'($urandom_range(0, 1)));
        end
        send_byte(fbuf[9], sm_last);
    endtask

    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(0, 16));
            2: return 8'($urandom_range(0, 90));
            default: return 8'($urandom_range(180, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_known_cmd();
        case ($urandom_range(0, 4))
            0: return CMD_FITNESS;
            1: return CMD_LIMITS;
            2: return CMD_CRASH;
            3: return CMD_IGNORE_A;
            default: return CMD_IGNORE_B;
        endcase
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_due != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_id(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_id = v;
    endtask

    task automatic random_unit();
        int r;
        int n;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        fbuf[0] = cur_id;
        for (int k = 2; k < 9; k++)
        begin
            fbuf[k] = pick_data();
        end
        if (r < 28)
        begin
            fbuf[1] = CMD_FITNESS;
            if ($urandom_range(0, 1) == 1)
            begin
                fbuf[7] = ($urandom_range(0, 1) == 1) ? CLEAR_CODE_L : CLEAR_CODE_R;
            end
            send_frame(1'b0, 1'($urandom_range(0, 1)));
        end
        else if (r < 50)
        begin
            fbuf[1] = CMD_LIMITS;
            send_frame(1'b0, 1'($urandom_range(0, 1)));
        end
        else if (r < 64)
        begin
            fbuf[1] = CMD_CRASH;
            send_frame(1'b0, 1'($urandom_range(0, 1)));
        end
        else if (r < 72)
        begin
            fbuf[1] = ($urandom_range(0, 1) == 1) ? CMD_IGNORE_A : CMD_IGNORE_B;
            send_frame(1'b0, 1'($urandom_range(0, 1)));
        end
        else if (r < 82)
        begin
            fbuf[1] = pick_known_cmd();
            send_frame(1'b1, 1'($urandom_range(0, 1)));
        end
        else if (r < 90)
        begin
            // right id, unknown command
            b = 8'($urandom);
            if (b == CMD_FITNESS || b == CMD_LIMITS || b == CMD_CRASH || b == CMD_IGNORE_A
                || b == CMD_IGNORE_B)
            begin
                b = 8'h00;
            end
            send_byte(cur_id, 1'($urandom_range(0, 1)));
            send_byte(b, 1'($urandom_range(0, 1)));
        end
        else if (r < 95)
        begin
            // truncated frame, the next unit runs into it
            n = $urandom_range(0, 6);
            send_byte(cur_id, 1'($urandom_range(0, 1)));
            send_byte(pick_known_cmd(), 1'($urandom_range(0, 1)));
            repeat (n) send_byte(pick_data(), 1'($urandom_range(0, 1)));
        end
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        logic [7:0] next_id;
        int target;
        int n;
        cur_id = DEVICE_ID_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // wrong first word, then unknown command
        send_byte(8'h37, 1'b0);
        send_byte(cur_id, 1'b1);
        send_byte(8'h99, 1'b0);

        // fitness with left torque clamped high, right torque at zero, clear left
        fbuf[0] = cur_id;
        fbuf[1] = CMD_FITNESS;
        fbuf[2] = 8'hFF;
        fbuf[3] = 8'hFF;
        fbuf[4] = 8'h00;
        fbuf[5] = 8'hFF;
        fbuf[6] = 8'h00;
        fbuf[7] = CLEAR_CODE_L;
        fbuf[8] = 8'hFF;
        send_frame(1'b0, 1'b0);

        // limits, every data word at its maximum
        fbuf[1] = CMD_LIMITS;
        for (int k = 2; k < 9; k++)
        begin
            fbuf[k] = 8'hFF;
        end
        send_frame(1'b0, 1'b0);
        drain();

        target = items;
        for (int phase = 0; phase < 4; phase++)
        begin
            // leave a frame half done so the id change lands mid-frame
            n = $urandom_range(0, 5);
            send_byte(cur_id, 1'b0);
            send_byte(CMD_LIMITS, 1'b0);
            repeat (n) send_byte(pick_data(), 1'($urandom_range(0, 1)));
            drain();
            case (phase)
                0: next_id = 8'h00;
                1: next_id = 8'hFF;
                default:
                begin
                    next_id = 8'($urandom);
                    while (next_id == cur_id)
                    begin
                        next_id = 8'($urandom);
                    end
                end
            endcase
            write_id(next_id);
            target = target + PHASE_ITEMS;
            while (items < target)
            begin
                calm = (phase == 2) || ($urandom_range(0, 7) == 0);
                random_unit();
            end
            drain();
        end

        if (faults == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
